>>> design/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

  // Coordinate format of all points, signed two's complement.
  localparam int COORD_WIDTH_DEF = 24;

  // Pipeline stages ahead of the divider: input differences, cross products,
  // signs and denominator, split products, numerator magnitude.
  localparam int PRE_STAGES = 5;

endpackage

`default_nettype wire

>>> design/rsi_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num < den * 2**QB, so the upper part of num starts below den.
module rsi_div #(
  parameter int NW = 76,
  parameter int DW = 52,
  parameter int QB = 25,
  parameter int SW = 26
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic      [QB-1:0] quo,
  output logic               rem_nz,
  output logic      [SW-1:0] side_out
);

  logic [DW-1:0] rem_r  [QB];
  logic [QB-1:0] sh_r   [QB];
  logic [DW-1:0] ud_r   [QB];
  logic [SW-1:0] sd_r   [QB];

  logic [DW-1:0] rem_in [QB];
  logic [QB-1:0] sh_in  [QB];
  logic [DW-1:0] ud_in  [QB];
  logic [SW-1:0] sd_in  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW-1:0] trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QB-1:0] sh_nxt;

    if (k == 0) begin : g_first
      assign rem_in[k] = DW'(num[NW-1:QB]);
      assign sh_in[k]  = num[QB-1:0];
      assign ud_in[k]  = den;
      assign sd_in[k]  = side_in;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign sh_in[k]  = sh_r[k-1];
      assign ud_in[k]  = ud_r[k-1];
      assign sd_in[k]  = sd_r[k-1];
    end

    // The shift register feeds numerator bits out at the top and collects
    // quotient bits at the bottom.
    assign trial   = {rem_in[k][DW-2:0], sh_in[k][QB-1]};
    assign ge      = (trial >= ud_in[k]);
    assign rem_nxt = ge ? (trial - ud_in[k]) : trial;
    assign sh_nxt  = {sh_in[k][QB-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        sh_r[k]  <= sh_nxt;
        ud_r[k]  <= ud_in[k];
        sd_r[k]  <= sd_in[k];
      end
    end
  end

  assign quo      = sh_r[QB-1];
  assign rem_nz   = |rem_r[QB-1];
  assign side_out = sd_r[QB-1];

endmodule

`default_nettype wire

>>> design/ray_segment_intersect.sv
// An input beat passes through the pre-divider stages, the divider stages and the output register to its result beat.
// Throughput: one test per cycle while the pipeline is not held; the divider spends one stage per quotient bit.
// The whole pipeline holds while a result waits on out_tready.
// Reset: synchronous active-low rst_n clears every valid bit; data is not reset.
`default_nettype none

module ray_segment_intersect #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // ray_origin_x, ray_origin_y, ray_through_x, ray_through_y,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y
  input  wire logic [8*COORD_WIDTH-1:0]             in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // hit_x, hit_y, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        out_tdata,
  // hit
  output logic                                      out_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int DFW = CW + 1;
  localparam int PW  = 2 * DFW;
  localparam int XW  = PW + 1;
  localparam int DW  = XW + 1;
  localparam int LW  = CW + 2;
  localparam int HW  = XW - LW;
  localparam int NW  = DFW + XW;
  localparam int QB  = CW + 1;
  localparam int SW  = CW + 2;
  localparam int NS  = rsi_pkg::PRE_STAGES + QB + 1;
  localparam int OW  = ((2*CW+7)/8)*8;

  logic          en;
  logic [NS-1:0] vld_r;

  assign en         = out_tready || !out_tvalid;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  logic signed [CW-1:0] ax, ay, bx, by, sx, sy, ex, ey;
  assign ax = in_tdata[0*CW +: CW];
  assign ay = in_tdata[1*CW +: CW];
  assign bx = in_tdata[2*CW +: CW];
  assign by = in_tdata[3*CW +: CW];
  assign sx = in_tdata[4*CW +: CW];
  assign sy = in_tdata[5*CW +: CW];
  assign ex = in_tdata[6*CW +: CW];
  assign ey = in_tdata[7*CW +: CW];

  // Stage 1: coordinate differences.
  logic signed [DFW-1:0] bax_r, bay_r, sxb_r, syb_r, exb_r, eyb_r;
  logic signed [DFW-1:0] dx1_r, dy1_r, aex_r, aey_r;
  logic signed [CW-1:0]  sx1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bax_r <= DFW'(bx) - DFW'(ax);
      bay_r <= DFW'(by) - DFW'(ay);
      sxb_r <= DFW'(sx) - DFW'(bx);
      syb_r <= DFW'(sy) - DFW'(by);
      exb_r <= DFW'(ex) - DFW'(bx);
      eyb_r <= DFW'(ey) - DFW'(by);
      dx1_r <= DFW'(ex) - DFW'(sx);
      dy1_r <= DFW'(ey) - DFW'(sy);
      aex_r <= DFW'(ax) - DFW'(ex);
      aey_r <= DFW'(ay) - DFW'(ey);
      sx1_r <= sx;
      sy1_r <= sy;
    end
  end

  // Stage 2: the six products of the three cross products.
  logic signed [PW-1:0]  p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [DFW-1:0] dx2_r, dy2_r;
  logic signed [CW-1:0]  sx2_r, sy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= bax_r * syb_r;
      p2_r  <= bay_r * sxb_r;
      p3_r  <= bax_r * eyb_r;
      p4_r  <= bay_r * exb_r;
      p5_r  <= dx1_r * aey_r;
      p6_r  <= dy1_r * aex_r;
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
    end
  end

  // Stage 3: side tests and the denominator sA - sB.
  logic signed [XW-1:0]  sa_c, sb_c, so_c;
  logic                  hit_c;
  logic signed [XW-1:0]  sa3_r;
  logic signed [DW-1:0]  den3_r;
  logic                  hit3_r;
  logic signed [DFW-1:0] dx3_r, dy3_r;
  logic signed [CW-1:0]  sx3_r, sy3_r;

  assign sa_c  = XW'(p1_r) - XW'(p2_r);
  assign sb_c  = XW'(p3_r) - XW'(p4_r);
  assign so_c  = XW'(p5_r) - XW'(p6_r);
  assign hit_c = (sa_c < 0 && sb_c > 0 && so_c > 0) || (sa_c > 0 && sb_c < 0 && so_c < 0);

  always_ff @(posedge clk) begin
    if (en) begin
      sa3_r  <= sa_c;
      den3_r <= DW'(sa_c) - DW'(sb_c);
      hit3_r <= hit_c;
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
    end
  end

  // Stage 4: delta times sA, split into a low and a high partial product.
  logic signed [DFW+LW:0]   pxl_r, pyl_r;
  logic signed [DFW+HW-1:0] pxh_r, pyh_r;
  logic signed [DW-1:0]     den4_r;
  logic                     hit4_r;
  logic signed [CW-1:0]     sx4_r, sy4_r;
  logic signed [LW:0]       sa_lo;
  logic signed [HW-1:0]     sa_hi;

  assign sa_lo = $signed({1'b0, sa3_r[LW-1:0]});
  assign sa_hi = $signed(sa3_r[XW-1:LW]);

  always_ff @(posedge clk) begin
    if (en) begin
      pxl_r  <= dx3_r * sa_lo;
      pyl_r  <= dy3_r * sa_lo;
      pxh_r  <= dx3_r * sa_hi;
      pyh_r  <= dy3_r * sa_hi;
      den4_r <= den3_r;
      hit4_r <= hit3_r;
      sx4_r  <= sx3_r;
      sy4_r  <= sy3_r;
    end
  end

  // Stage 5: numerator and denominator magnitudes for the divider.
  logic signed [NW-1:0] nx_c, ny_c;
  logic [NW-1:0]        unx_r, uny_r;
  logic [DW-1:0]        ud_r;
  logic                 negx_r, negy_r, hit5_r;
  logic signed [CW-1:0] sx5_r, sy5_r;

  assign nx_c = (NW'(pxh_r) <<< LW) + NW'(pxl_r);
  assign ny_c = (NW'(pyh_r) <<< LW) + NW'(pyl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      unx_r  <= nx_c[NW-1] ? (~nx_c + 1'b1) : nx_c;
      uny_r  <= ny_c[NW-1] ? (~ny_c + 1'b1) : ny_c;
      ud_r   <= den4_r[DW-1] ? (~den4_r + 1'b1) : den4_r;
      negx_r <= nx_c[NW-1] ^ den4_r[DW-1];
      negy_r <= ny_c[NW-1] ^ den4_r[DW-1];
      hit5_r <= hit4_r;
      sx5_r  <= sx4_r;
      sy5_r  <= sy4_r;
    end
  end

  logic [QB-1:0] qx, qy;
  logic          rnzx, rnzy;
  logic [SW-1:0] sdx, sdy;

  rsi_div #(.NW(NW), .DW(DW), .QB(QB), .SW(SW)) u_div_x (
    .clk      (clk),
    .en       (en),
    .num      (unx_r),
    .den      (ud_r),
    .side_in  ({hit5_r, negx_r, sx5_r}),
    .quo      (qx),
    .rem_nz   (rnzx),
    .side_out (sdx)
  );

  rsi_div #(.NW(NW), .DW(DW), .QB(QB), .SW(SW)) u_div_y (
    .clk      (clk),
    .en       (en),
    .num      (uny_r),
    .den      (ud_r),
    .side_in  ({hit5_r, negy_r, sy5_r}),
    .quo      (qy),
    .rem_nz   (rnzy),
    .side_out (sdy)
  );

  // Final stage: start point plus truncated offset. A nonzero remainder
  // moves the sum one step toward zero when the offset and sum differ in sign.
  logic signed [CW+1:0] qsx, qsy, vx, vy, rx, ry;
  logic                 hit_f, nx_f, ny_f;
  logic signed [CW-1:0] hx_r, hy_r;
  logic                 hit_r;

  assign hit_f = sdx[SW-1];
  assign nx_f  = sdx[SW-2];
  assign ny_f  = sdy[SW-2];
  assign qsx   = $signed({1'b0, qx});
  assign qsy   = $signed({1'b0, qy});
  assign vx    = (CW+2)'($signed(sdx[CW-1:0])) + (nx_f ? -qsx : qsx);
  assign vy    = (CW+2)'($signed(sdy[CW-1:0])) + (ny_f ? -qsy : qsy);

  always_comb begin
    rx = vx;
    if (rnzx && !nx_f && vx < 0) rx = vx + (CW+2)'(1);
    if (rnzx && nx_f && vx > 0)  rx = vx - (CW+2)'(1);
    ry = vy;
    if (rnzy && !ny_f && vy < 0) ry = vy + (CW+2)'(1);
    if (rnzy && ny_f && vy > 0)  ry = vy - (CW+2)'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_f;
      hx_r  <= hit_f ? rx[CW-1:0] : '0;
      hy_r  <= hit_f ? ry[CW-1:0] : '0;
    end
  end

  assign out_tuser = hit_r;
  assign out_tdata = OW'({hy_r, hx_r});

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> hx_r == '0 && hy_r == '0)
    else $error("miss with nonzero coordinates");

  a_hit_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && hit3_r |-> den3_r != '0)
    else $error("hit with zero denominator");
`endif

endmodule

`default_nettype wire
